/* design/blvg_pkg.sv */
// Package for the bearing line-of-sight variance guard.
// Word types and fixed widths shared by the interfaces, the top-level module and the testbench.
package blvg_pkg;

    localparam int NUM_W = 84;
    localparam int DEN_W = 50;
    localparam int QUO_W = 34;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = -32'sh7FFF_FFFF - 32'sh1;

    typedef struct packed {
        logic        [30:0] pre_xx;
        logic signed [31:0] pre_xy;
        logic signed [31:0] pre_yx;
        logic        [30:0] pre_yy;
        logic        [30:0] post_xx;
        logic signed [31:0] post_xy;
        logic signed [31:0] post_yx;
        logic        [30:0] post_yy;
        logic signed [23:0] target_east;
        logic signed [23:0] target_north;
        logic signed [23:0] sensor_east;
        logic signed [23:0] sensor_north;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_xx;
        logic signed [31:0] out_xy;
        logic signed [31:0] out_yx;
        logic signed [31:0] out_yy;
        logic               guard_applied;
    } t_out_word;

endpackage

/* design/blvg_in_if.sv */
// Input channel: valid/ready handshake carrying one covariance pair word.
// Depends on blvg_pkg.
interface blvg_in_if import blvg_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/blvg_out_if.sv */
// Output channel: valid/ready handshake carrying one guarded covariance word.
// Depends on blvg_pkg.
interface blvg_out_if import blvg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/blvg_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// Carries a sideband vector alongside; no package dependencies.
module blvg_div_pipe #(
    parameter int NW   = 84,
    parameter int DW   = 50,
    parameter int QW   = 34,
    parameter int NUMS = 1,
    parameter int SW   = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num [NUMS],
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo [NUMS],
    output logic [SW-1:0] o_side
);

    logic          r_v    [QW];
    logic [NW-1:0] r_rem  [QW][NUMS];
    logic [QW-1:0] r_quo  [QW][NUMS];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic          w_v;
        logic [NW-1:0] w_rem [NUMS];
        logic [QW-1:0] w_quo [NUMS];
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic [NW-1:0] w_trial;
        logic [NW-1:0] n_rem [NUMS];
        logic [QW-1:0] n_quo [NUMS];

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_den  = i_den;
            assign w_side = i_side;
            for (genvar j = 0; j < NUMS; j++) begin : g_lane
                assign w_rem[j] = i_num[j];
                assign w_quo[j] = '0;
            end
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            for (genvar j = 0; j < NUMS; j++) begin : g_lane
                assign w_rem[j] = r_rem[k-1][j];
                assign w_quo[j] = r_quo[k-1][j];
            end
        end

        assign w_trial = NW'(w_den) << B;

        for (genvar j = 0; j < NUMS; j++) begin : g_sub
            always_comb begin
                n_rem[j] = w_rem[j];
                n_quo[j] = w_quo[j];
                if (w_rem[j] >= w_trial) begin
                    n_rem[j]    = w_rem[j] - w_trial;
                    n_quo[j][B] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][j] <= n_rem[j];
                    r_quo[k][j] <= n_quo[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    for (genvar j = 0; j < NUMS; j++) begin : g_out
        assign o_quo[j] = r_quo[QW-1][j];
    end

endmodule

/* design/bearing_los_variance_guard.sv */
// Bearing line-of-sight variance guard, top level.
// Depends on blvg_pkg, blvg_in_if, blvg_out_if and blvg_div_pipe.
//
// Takes one covariance pair word per cycle while the output buffer is not full
// and returns one guarded word per word taken, in order. On its way to the
// output buffer a word passes five stages that form the line-of-sight
// quadratic form, a 34-stage divider that gives the lost variance, two
// stages that form the spread products and a second 34-stage divider
// (three lanes) that projects it onto the axes. A two-word output buffer
// holds results; the pipeline stalls as a whole only when that buffer is full.
module bearing_los_variance_guard import blvg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blvg_in_if.sink     i_in,
    blvg_out_if.source  o_out
);

    typedef struct packed {
        logic        [30:0] xx;
        logic        [30:0] yy;
        logic signed [31:0] xy;
        logic signed [31:0] yx;
    } t_post;

    typedef struct packed {
        logic         guard;
        logic [49:0]  r2;
        logic [48:0]  dxx;
        logic [48:0]  dyy;
        logic [48:0]  mdxy;
        logic         sxy;
        t_post        q;
    } t_side1;

    typedef struct packed {
        logic  guard;
        logic  sxy;
        t_post q;
    } t_side2;

    logic      w_en;
    t_in_word  w_in;

    // stage A
    logic               r_a_v;
    logic signed [24:0] r_a_dx, r_a_dy;
    logic signed [31:0] r_a_cxx, r_a_cyy;
    logic signed [33:0] r_a_cxy;
    t_post              r_a_q;
    logic signed [24:0] n_a_dx, n_a_dy;
    logic signed [31:0] n_a_cxx, n_a_cyy;
    logic        [33:0] n_a_cxy;

    // stage B
    logic               r_b_v;
    logic        [48:0] r_b_dxx, r_b_dyy;
    logic signed [49:0] r_b_dxy;
    logic signed [31:0] r_b_cxx, r_b_cyy;
    logic signed [33:0] r_b_cxy;
    t_post              r_b_q;
    logic signed [49:0] n_b_sqx, n_b_sqy, n_b_dxy;

    // stage C
    logic        r_c_v;
    logic [49:0] r_c_r2;
    logic [48:0] r_c_dxx, r_c_dyy, r_c_mdxy;
    logic        r_c_sdxy, r_c_sxx, r_c_sxy, r_c_syy;
    logic [55:0] r_c_pxx_l, r_c_pyy_l;
    logic [56:0] r_c_pxx_h, r_c_pyy_h;
    logic [57:0] r_c_pxy_l;
    logic [58:0] r_c_pxy_h;
    t_post       r_c_q;
    logic [31:0] n_c_mcxx, n_c_mcyy;
    logic [33:0] n_c_mcxy;
    logic [48:0] n_c_mdxy;

    // stage D
    logic        r_d_v;
    logic [49:0] r_d_r2;
    logic [48:0] r_d_dxx, r_d_dyy, r_d_mdxy;
    logic        r_d_sdxy;
    logic [84:0] r_d_txx, r_d_txy, r_d_tyy;
    t_post       r_d_q;
    logic [83:0] n_d_mxx, n_d_mxy, n_d_myy;

    // stage E
    logic        r_e_v;
    logic [84:0] r_e_num;
    logic        r_e_guard;
    logic [49:0] r_e_r2;
    logic [48:0] r_e_dxx, r_e_dyy, r_e_mdxy;
    logic        r_e_sdxy;
    t_post       r_e_q;
    logic [84:0] n_e_num;

    // divider 1
    t_side1      w_s1_in, w_s1;
    logic [NUM_W-1:0] w_d1_num [1];
    logic [QUO_W-1:0] w_d1_quo [1];
    logic             w_d1_v;
    logic [$bits(t_side1)-1:0] w_d1_side;

    // stage F
    logic        r_f_v;
    logic [57:0] r_f_pxx_l, r_f_pyy_l, r_f_pxy_l;
    logic [58:0] r_f_pxx_h, r_f_pyy_h, r_f_pxy_h;
    logic [49:0] r_f_r2;
    t_side2      r_f_s;
    logic [QUO_W-1:0] w_delta;

    // stage G
    logic        r_g_v;
    logic [NUM_W-1:0] r_g_num [3];
    logic [49:0] r_g_r2;
    t_side2      r_g_s;

    // divider 2
    logic [QUO_W-1:0] w_d2_quo [3];
    logic             w_d2_v;
    logic [$bits(t_side2)-1:0] w_d2_side;
    t_side2           w_s2;

    // result and output buffer
    t_out_word          w_res;
    logic        [35:0] w_sum_xx, w_sum_yy;
    logic signed [36:0] w_axy, w_sxy, w_half;
    t_out_word          r_buf [2];
    logic               r_wp, r_rp;
    logic        [1:0]  r_cnt;
    logic               w_push, w_pop;

    assign w_in       = i_in.data;
    assign w_en       = (r_cnt != 2'd2);
    assign i_in.ready = w_en;

    // ---------------- stage A: differences
    always_comb begin
        n_a_dx  = $signed({w_in.target_east[23], w_in.target_east})
                - $signed({w_in.sensor_east[23], w_in.sensor_east});
        n_a_dy  = $signed({w_in.target_north[23], w_in.target_north})
                - $signed({w_in.sensor_north[23], w_in.sensor_north});
        n_a_cxx = $signed({1'b0, w_in.pre_xx}) - $signed({1'b0, w_in.post_xx});
        n_a_cyy = $signed({1'b0, w_in.pre_yy}) - $signed({1'b0, w_in.post_yy});
        n_a_cxy = ({{2{w_in.pre_xy[31]}}, w_in.pre_xy}
                 + {{2{w_in.pre_yx[31]}}, w_in.pre_yx})
                - ({{2{w_in.post_xy[31]}}, w_in.post_xy}
                 + {{2{w_in.post_yx[31]}}, w_in.post_yx});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= w_d1_v;
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx  <= n_a_dx;
            r_a_dy  <= n_a_dy;
            r_a_cxx <= n_a_cxx;
            r_a_cyy <= n_a_cyy;
            r_a_cxy <= $signed(n_a_cxy);
            r_a_q   <= '{xx: w_in.post_xx, yy: w_in.post_yy,
                         xy: w_in.post_xy, yx: w_in.post_yx};
        end
    end

    // ---------------- stage B: squares and cross product of d
    assign n_b_sqx = r_a_dx * r_a_dx;
    assign n_b_sqy = r_a_dy * r_a_dy;
    assign n_b_dxy = r_a_dx * r_a_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_dxx <= n_b_sqx[48:0];
            r_b_dyy <= n_b_sqy[48:0];
            r_b_dxy <= n_b_dxy;
            r_b_cxx <= r_a_cxx;
            r_b_cyy <= r_a_cyy;
            r_b_cxy <= r_a_cxy;
            r_b_q   <= r_a_q;
        end
    end

    // ---------------- stage C: range and partial products of the form
    always_comb begin
        n_c_mcxx = r_b_cxx[31] ? 32'(-r_b_cxx) : 32'(r_b_cxx);
        n_c_mcyy = r_b_cyy[31] ? 32'(-r_b_cyy) : 32'(r_b_cyy);
        n_c_mcxy = r_b_cxy[33] ? 34'(-r_b_cxy) : 34'(r_b_cxy);
        n_c_mdxy = r_b_dxy[49] ? 49'(-r_b_dxy) : r_b_dxy[48:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_r2    <= {1'b0, r_b_dxx} + {1'b0, r_b_dyy};
            r_c_dxx   <= r_b_dxx;
            r_c_dyy   <= r_b_dyy;
            r_c_mdxy  <= n_c_mdxy;
            r_c_sdxy  <= r_b_dxy[49];
            r_c_sxx   <= r_b_cxx[31];
            r_c_syy   <= r_b_cyy[31];
            r_c_sxy   <= r_b_cxy[33] ^ r_b_dxy[49];
            r_c_pxx_l <= 56'(n_c_mcxx) * 56'(r_b_dxx[23:0]);
            r_c_pxx_h <= 57'(n_c_mcxx) * 57'(r_b_dxx[48:24]);
            r_c_pyy_l <= 56'(n_c_mcyy) * 56'(r_b_dyy[23:0]);
            r_c_pyy_h <= 57'(n_c_mcyy) * 57'(r_b_dyy[48:24]);
            r_c_pxy_l <= 58'(n_c_mcxy) * 58'(n_c_mdxy[23:0]);
            r_c_pxy_h <= 59'(n_c_mcxy) * 59'(n_c_mdxy[48:24]);
            r_c_q     <= r_b_q;
        end
    end

    // ---------------- stage D: signed terms
    assign n_d_mxx = 84'(r_c_pxx_l) + (84'(r_c_pxx_h) << 24);
    assign n_d_myy = 84'(r_c_pyy_l) + (84'(r_c_pyy_h) << 24);
    assign n_d_mxy = 84'(r_c_pxy_l) + (84'(r_c_pxy_h) << 24);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_txx  <= r_c_sxx ? -85'(n_d_mxx) : 85'(n_d_mxx);
            r_d_tyy  <= r_c_syy ? -85'(n_d_myy) : 85'(n_d_myy);
            r_d_txy  <= r_c_sxy ? -85'(n_d_mxy) : 85'(n_d_mxy);
            r_d_r2   <= r_c_r2;
            r_d_dxx  <= r_c_dxx;
            r_d_dyy  <= r_c_dyy;
            r_d_mdxy <= r_c_mdxy;
            r_d_sdxy <= r_c_sdxy;
            r_d_q    <= r_c_q;
        end
    end

    // ---------------- stage E: quadratic form and guard decision
    assign n_e_num = r_d_txx + r_d_txy + r_d_tyy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_num   <= n_e_num;
            r_e_guard <= (r_d_r2 != '0) && !n_e_num[84] && (n_e_num != '0);
            r_e_r2    <= r_d_r2;
            r_e_dxx   <= r_d_dxx;
            r_e_dyy   <= r_d_dyy;
            r_e_mdxy  <= r_d_mdxy;
            r_e_sdxy  <= r_d_sdxy;
            r_e_q     <= r_d_q;
        end
    end

    // ---------------- lost variance: num / r2
    assign w_d1_num[0] = r_e_num[NUM_W-1:0];
    assign w_s1_in = '{guard: r_e_guard, r2: r_e_r2, dxx: r_e_dxx, dyy: r_e_dyy,
                       mdxy: r_e_mdxy, sxy: r_e_sdxy, q: r_e_q};

    blvg_div_pipe #(
        .NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .NUMS(1), .SW($bits(t_side1))
    ) u_div_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_v),
        .i_num   (w_d1_num),
        .i_den   (r_e_r2),
        .i_side  (w_s1_in),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    assign w_s1    = t_side1'(w_d1_side);
    assign w_delta = w_d1_quo[0];

    // ---------------- stage F: delta times d_i d_j, partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_pxx_l <= 58'(w_delta) * 58'(w_s1.dxx[23:0]);
            r_f_pxx_h <= 59'(w_delta) * 59'(w_s1.dxx[48:24]);
            r_f_pyy_l <= 58'(w_delta) * 58'(w_s1.dyy[23:0]);
            r_f_pyy_h <= 59'(w_delta) * 59'(w_s1.dyy[48:24]);
            r_f_pxy_l <= 58'(w_delta) * 58'(w_s1.mdxy[23:0]);
            r_f_pxy_h <= 59'(w_delta) * 59'(w_s1.mdxy[48:24]);
            r_f_r2    <= w_s1.r2;
            r_f_s     <= '{guard: w_s1.guard, sxy: w_s1.sxy, q: w_s1.q};
        end
    end

    // ---------------- stage G: combine partials
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_num[0] <= NUM_W'(r_f_pxx_l) + (NUM_W'(r_f_pxx_h) << 24);
            r_g_num[1] <= NUM_W'(r_f_pyy_l) + (NUM_W'(r_f_pyy_h) << 24);
            r_g_num[2] <= NUM_W'(r_f_pxy_l) + (NUM_W'(r_f_pxy_h) << 24);
            r_g_r2     <= r_f_r2;
            r_g_s      <= r_f_s;
        end
    end

    // ---------------- per-axis restore: three lanes over r2
    blvg_div_pipe #(
        .NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .NUMS(3), .SW($bits(t_side2))
    ) u_div_axes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_v),
        .i_num   (r_g_num),
        .i_den   (r_g_r2),
        .i_side  (r_g_s),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    assign w_s2 = t_side2'(w_d2_side);

    // ---------------- final sums, symmetrize, saturate
    always_comb begin
        w_sum_xx = 36'(w_s2.q.xx) + 36'(w_d2_quo[0]);
        w_sum_yy = 36'(w_s2.q.yy) + 36'(w_d2_quo[1]);
        w_axy    = w_s2.sxy ? -37'(w_d2_quo[2]) : 37'(w_d2_quo[2]);
        w_sxy    = 37'(w_s2.q.xy) + 37'(w_s2.q.yx) + (w_axy <<< 1);
        w_half   = (w_sxy + $signed({36'd0, w_sxy[36]})) >>> 1;

        w_res.guard_applied = w_s2.guard;
        if (w_s2.guard) begin
            w_res.out_xx = (|w_sum_xx[35:31]) ? SAT_MAX : $signed({1'b0, w_sum_xx[30:0]});
            w_res.out_yy = (|w_sum_yy[35:31]) ? SAT_MAX : $signed({1'b0, w_sum_yy[30:0]});
            if (w_half > 37'(SAT_MAX)) begin
                w_res.out_xy = SAT_MAX;
            end else if (w_half < 37'(SAT_MIN)) begin
                w_res.out_xy = SAT_MIN;
            end else begin
                w_res.out_xy = w_half[31:0];
            end
            w_res.out_yx = w_res.out_xy;
        end else begin
            w_res.out_xx = $signed({1'b0, w_s2.q.xx});
            w_res.out_yy = $signed({1'b0, w_s2.q.yy});
            w_res.out_xy = w_s2.q.xy;
            w_res.out_yx = w_s2.q.yx;
        end
    end

    // ---------------- two-word output buffer
    assign w_push = w_en && w_d2_v;
    assign w_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_res;
        end
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_buf[r_rp];

    // ---------------- checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_a_v) && $stable(r_g_v))
        else $error("pipeline moved while stalled");

    a_sym_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.guard_applied |->
            o_out.data.out_xy == o_out.data.out_yx)
        else $error("guarded word not symmetric");

endmodule

/* tb/sv/testbench.sv */
// Testbench for bearing_los_variance_guard: directed and random covariance words,
// with random idling on both sides, checked against a built-in predictor.
// Depends on blvg_pkg, blvg_in_if, blvg_out_if and the block itself.
import blvg_pkg::*;

class guard_scoreboard;
    t_out_word guarded_q[$];
    int        errors;
    int        words_checked;
    int        guards_seen;

    function new();
        errors = 0;
        words_checked = 0;
        guards_seen = 0;
    endfunction

    function logic signed [31:0] sat32(longint v);
        if (v > longint'(SAT_MAX)) return SAT_MAX;
        if (v < longint'(SAT_MIN)) return SAT_MIN;
        return v[31:0];
    endfunction

    function t_out_word guarded_cov(t_in_word w);
        longint             dx, dy, dxx, dyy, dxy, adxy;
        longint             mxx, myy, moff, axx, ayy, axy, gxy, gyx;
        logic signed [127:0] lost;
        logic [127:0]       r2, delta;
        t_out_word          r;
        r.out_xx = {1'b0, w.post_xx};
        r.out_xy = w.post_xy;
        r.out_yx = w.post_yx;
        r.out_yy = {1'b0, w.post_yy};
        r.guard_applied = 1'b0;
        dx = longint'(w.target_east) - longint'(w.sensor_east);
        dy = longint'(w.target_north) - longint'(w.sensor_north);
        dxx = dx * dx;
        dyy = dy * dy;
        dxy = dx * dy;
        adxy = dxy < 0 ? -dxy : dxy;
        r2 = 128'(dxx + dyy);
        if (r2 != 0) begin
            mxx = longint'(w.pre_xx) - longint'(w.post_xx);
            myy = longint'(w.pre_yy) - longint'(w.post_yy);
            moff = (longint'(w.pre_xy) + longint'(w.pre_yx))
                 - (longint'(w.post_xy) + longint'(w.post_yx));
            lost = 128'(mxx) * 128'(dxx) + 128'(moff) * 128'(dxy)
                 + 128'(myy) * 128'(dyy);
            if (lost > 0) begin
                delta = lost / r2;
                axx = longint'(64'(delta * 128'(dxx) / r2));
                ayy = longint'(64'(delta * 128'(dyy) / r2));
                axy = longint'(64'(delta * 128'(adxy) / r2));
                if (dxy < 0) axy = -axy;
                gxy = longint'(w.post_xy) + axy;
                gyx = longint'(w.post_yx) + axy;
                r.out_xx = sat32(longint'(w.post_xx) + axx);
                r.out_yy = sat32(longint'(w.post_yy) + ayy);
                r.out_xy = sat32((gxy + gyx) / 2);
                r.out_yx = r.out_xy;
                r.guard_applied = 1'b1;
            end
        end
        return r;
    endfunction

    function void note_input(t_in_word w);
        guarded_q.push_back(guarded_cov(w));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
        errors++;
    endtask

    task check_result(t_out_word got);
        t_out_word want;
        if (guarded_q.size() == 0) begin
            report("unexpected word", got.out_xx, 0);
            return;
        end
        want = guarded_q.pop_front();
        if (got.out_xx !== want.out_xx) report("out_xx", got.out_xx, want.out_xx);
        if (got.out_xy !== want.out_xy) report("out_xy", got.out_xy, want.out_xy);
        if (got.out_yx !== want.out_yx) report("out_yx", got.out_yx, want.out_yx);
        if (got.out_yy !== want.out_yy) report("out_yy", got.out_yy, want.out_yy);
        if (got.guard_applied !== want.guard_applied)
            report("guard_applied", got.guard_applied, want.guard_applied);
        if (want.guard_applied) guards_seen++;
        words_checked++;
    endtask

    function int pending();
        return guarded_q.size();
    endfunction
endclass

module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blvg_in_if  in_if();
    blvg_out_if out_if();

    bearing_los_variance_guard dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    guard_scoreboard sb = new();
    int rx_hold = 0;
    bit quiet = 0;

    always #6 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    task send_word(t_in_word w);
        in_if.valid <= 1'b1;
        in_if.data <= w;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(w);
    endtask

    task idle_tx(int n);
        in_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function logic [31:0] rand_mag();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function t_in_word rand_word();
        t_in_word w;
        int       shift;
        w.pre_xx = 31'($urandom);
        w.pre_xy = $urandom;
        w.pre_yx = $urandom;
        w.pre_yy = 31'($urandom);
        w.sensor_east = 24'($urandom);
        w.sensor_north = 24'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                w.post_xx = 31'($urandom);
                w.post_xy = $urandom;
                w.post_yx = $urandom;
                w.post_yy = 31'($urandom);
            end
            default: begin
                w.pre_xx = 31'(rand_mag());
                w.pre_yy = 31'(rand_mag());
                w.pre_xy = $signed(rand_mag()) >>> $urandom_range(0, 2);
                w.pre_yx = w.pre_xy + $signed(rand_mag() >> 8);
                shift = $urandom_range(0, 6);
                w.post_xx = w.pre_xx >> shift;
                w.post_yy = w.pre_yy >> $urandom_range(0, 6);
                w.post_xy = w.pre_xy >>> shift;
                w.post_yx = w.pre_yx >>> shift;
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            w.target_east = 24'($urandom);
            w.target_north = 24'($urandom);
        end else begin
            w.target_east = 24'(w.sensor_east
                                + ($signed($urandom) >>> $urandom_range(8, 31)));
            w.target_north = 24'(w.sensor_north
                                 + ($signed($urandom) >>> $urandom_range(8, 31)));
        end
        return w;
    endfunction

    initial begin
        t_in_word w;
        t_in_word dir_q[$];
        int n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all zero, zero range with distinct covariances
        w = '0;
        dir_q.push_back(w);
        w.pre_xx = 31'h7FFF_FFFF; w.pre_yy = 31'h7FFF_FFFF;
        w.pre_xy = 32'sh7FFF_FFFF; w.pre_yx = SAT_MIN;
        w.target_east = 24'sh12_3456; w.sensor_east = 24'sh12_3456;
        dir_q.push_back(w);
        // no variance lost: pre equals post, and post larger than pre
        w = '0;
        w.pre_xx = 31'h0001_0000; w.post_xx = 31'h0001_0000;
        w.target_east = 24'sh00_0100;
        dir_q.push_back(w);
        w.post_xx = 31'h0100_0000; w.post_yy = 31'h7FFF_FFFF;
        w.target_north = 24'sh7F_FFFF;
        dir_q.push_back(w);
        // negative lost variance over full-range positions: guard not applied
        w = '0;
        w.pre_xx = 31'h0000_0001;
        w.target_east = 24'sh7F_FFFF; w.sensor_east = 24'sh80_0000;
        w.target_north = 24'sh7F_FFFF; w.sensor_north = 24'sh80_0000;
        w.post_xy = 32'sh0000_0003; w.post_yx = 32'sh0000_0000;
        dir_q.push_back(w);
        // positive saturation on the diagonal
        w = '0;
        w.pre_xx = 31'h7FFF_FFFF; w.pre_yy = 31'h7FFF_FFFF;
        w.post_xx = 31'h7FFF_FFF0; w.post_yy = 31'h7FFF_FFF0;
        w.pre_xy = 32'sh7FFF_FFFF; w.pre_yx = 32'sh7FFF_FFFF;
        w.post_xy = 32'sh7FFF_FF00; w.post_yx = 32'sh7FFF_FF00;
        w.target_east = 24'sh00_1000; w.target_north = 24'sh00_1000;
        dir_q.push_back(w);
        // negative saturation of the cross terms
        w.pre_xy = SAT_MIN; w.pre_yx = SAT_MIN;
        w.post_xy = SAT_MIN; w.post_yx = SAT_MIN;
        w.target_north = 24'sh80_0000; w.sensor_north = 24'sh7F_FFFF;
        w.post_xx = 31'h0; w.post_yy = 31'h0;
        dir_q.push_back(w);
        // position extremes along one axis each
        w = '0;
        w.pre_xx = 31'h7FFF_FFFF; w.pre_yy = 31'h7FFF_FFFF;
        w.target_east = 24'sh80_0000; w.sensor_east = 24'sh7F_FFFF;
        dir_q.push_back(w);
        w.target_east = 24'sh0; w.sensor_east = 24'sh0;
        w.target_north = 24'sh7F_FFFF; w.sensor_north = 24'sh80_0000;
        dir_q.push_back(w);
        // odd cross sums: positive average, then negative average truncating toward zero
        w = '0;
        w.pre_xy = 32'sh0001_0000; w.pre_yx = 32'sh0001_0000;
        w.post_xy = -32'sh0000_0003; w.post_yx = 32'sh0000_0000;
        w.target_east = 24'sh00_0001; w.target_north = 24'sh00_0001;
        dir_q.push_back(w);
        w.target_north = -24'sh00_0001;
        w.pre_xy = SAT_MIN; w.pre_yx = SAT_MIN;
        dir_q.push_back(w);
        for (int i = 0; i < 6; i++) dir_q.push_back(rand_word());
        foreach (dir_q[i]) send_word(dir_q[i]);

        n = 1500;
        for (int i = 0; i < n; i++) begin
            if (i == n - 200) quiet = 1;
            if (i == 300) rx_hold = 400;
            if (i == 700) begin
                in_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if (!quiet && $urandom_range(0, 9) == 0) idle_tx($urandom_range(1, 17));
            send_word(rand_word());
        end
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("checked %0d guarded words, guard applied on %0d", sb.words_checked,
                 sb.guards_seen);
        $display("covered zero range, no loss, truncation, saturation and stalled output");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end
endmodule
